// ===== rtl/core/pmrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrt_pkg
// Shared types, constants and helpers for the peer max RSSI table.
// ----------------------------------------------------------------------------
package pmrt_pkg;

	localparam int unsigned SLOTS_DEF     = 8;
	localparam int unsigned KEY_BYTES_DEF = 8;
	localparam int unsigned KEY_W         = 64;
	localparam int unsigned RSSI_W        = 8;
	localparam int unsigned FUNC_W        = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_CLEAR = 2'd0,
		FN_NOTE  = 2'd1,
		FN_FLUSH = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	typedef struct packed {
		logic [KEY_W-1:0]         key;
		logic signed [RSSI_W-1:0] best;
		logic                     found;
		logic                     last;
	} res_t;

	// Keep the name up to its first zero byte and at most nbytes bytes.
	function automatic logic [KEY_W-1:0] name_key(input logic [KEY_W-1:0] raw,
			input int unsigned nbytes);
		logic [KEY_W-1:0] k;
		logic             stop;
		k    = '0;
		stop = 1'b0;
		for (int unsigned b = 0; b < KEY_W / 8; b++) begin
			if (b >= nbytes || raw[8*b +: 8] == 8'h00) begin
				stop = 1'b1;
			end
			if (!stop) begin
				k[8*b +: 8] = raw[8*b +: 8];
			end
		end
		return k;
	endfunction

endpackage

// ===== rtl/core/pmrt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrt_if
// Valid/ready channels for sightings in and table reports out.
// ----------------------------------------------------------------------------
interface pmrt_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [pmrt_pkg::FUNC_W-1:0]          func;
	logic [pmrt_pkg::KEY_W-1:0]           peer_key;
	logic signed [pmrt_pkg::RSSI_W-1:0]   rssi;

	modport source (output valid, func, peer_key, rssi, input ready);
	modport sink   (input valid, func, peer_key, rssi, output ready);
endinterface

interface pmrt_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [pmrt_pkg::KEY_W-1:0]           out_key;
	logic signed [pmrt_pkg::RSSI_W-1:0]   peak_rssi;
	logic                                 found;
	logic                                 last;

	modport source (output valid, out_key, peak_rssi, found, last, input ready);
	modport sink   (input valid, out_key, peak_rssi, found, last, output ready);
endinterface

// ===== rtl/core/peer_max_rssi_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_max_rssi_table_unit
// Per-peer strongest RSSI table: clear, note sighting, flush valid slots.
// ----------------------------------------------------------------------------
//  channel    dir  handshake     payload
//  sighting   in   valid/ready   func, peer_key, rssi
//  report     out  valid/ready   out_key, peak_rssi, found, last
//
// Clear drops every valid bit. Note walks the slot RAM one slot a cycle, as
// set by the single RAM read port; a match ends the walk early. Flush reads
// the slots in order and reports each valid one, holding while the sink
// stalls a report; an empty table gives a single not-found report.
// Reset clears the valid bits at once; the slot RAM needs no clearing.
// ----------------------------------------------------------------------------
module peer_max_rssi_table_unit #(
	parameter int unsigned SLOTS     = pmrt_pkg::SLOTS_DEF,
	parameter int unsigned KEY_BYTES = pmrt_pkg::KEY_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pmrt_in_if.sink    sighting,
	pmrt_out_if.source report
);

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned MW = 8 * KEY_BYTES + pmrt_pkg::RSSI_W;

	logic           ram_we;
	logic [IW-1:0]  ram_waddr;
	logic [MW-1:0]  ram_wdata;
	logic           ram_re;
	logic [IW-1:0]  ram_raddr;
	logic [MW-1:0]  ram_rdata;
	logic           out_free;
	logic           push;
	pmrt_pkg::res_t res;

	pmrt_ram #(
		.WIDTH(MW),
		.DEPTH(SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pmrt_walk #(
		.SLOTS     (SLOTS),
		.KEY_BYTES (KEY_BYTES)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.sighting  (sighting),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_free  (out_free),
		.push      (push),
		.res       (res)
	);

	pmrt_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.res    (res),
		.free   (out_free),
		.report (report)
	);

endmodule

// ===== rtl/core/pmrt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pmrt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/pmrt_obuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrt_obuf
// Output register for report transfers; frees itself as the sink takes one.
// ----------------------------------------------------------------------------
module pmrt_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pmrt_pkg::res_t     res,
	output logic               free,
	pmrt_out_if.source         report
);

	logic           valid_q;
	pmrt_pkg::res_t res_q;

	assign free = !valid_q || report.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (report.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign report.valid     = valid_q;
	assign report.out_key   = res_q.key;
	assign report.peak_rssi = res_q.best;
	assign report.found     = res_q.found;
	assign report.last      = res_q.last;

endmodule

// ===== rtl/core/pmrt_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrt_walk
// Slot sequencer: valid bits, slot walk over the RAM, key match and update.
// ----------------------------------------------------------------------------
module pmrt_walk #(
	parameter int unsigned SLOTS     = pmrt_pkg::SLOTS_DEF,
	parameter int unsigned KEY_BYTES = pmrt_pkg::KEY_BYTES_DEF,
	localparam int unsigned IW       = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int unsigned CW       = $clog2(SLOTS + 1),
	localparam int unsigned KW       = 8 * KEY_BYTES,
	localparam int unsigned MW       = KW + pmrt_pkg::RSSI_W
) (
	input  logic               clk,
	input  logic               arst_n,
	pmrt_in_if.sink            sighting,
	// RAM ports
	output logic               ram_we,
	output logic [IW-1:0]      ram_waddr,
	output logic [MW-1:0]      ram_wdata,
	output logic               ram_re,
	output logic [IW-1:0]      ram_raddr,
	input  logic [MW-1:0]      ram_rdata,
	// output register
	input  logic               out_free,
	output logic               push,
	output pmrt_pkg::res_t     res
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_NOTE  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_EMPTY = 4'b1000
	} state_t;

	state_t                             state_q;
	logic [SLOTS-1:0]                   valid_q;
	logic [KW-1:0]                      key_q;
	logic signed [pmrt_pkg::RSSI_W-1:0] rssi_q;
	logic [CW-1:0]                      iss_q;
	logic                               v_s1;
	logic [IW-1:0]                      idx_s1;
	logic                               free_found_q;
	logic [IW-1:0]                      free_idx_q;

	logic                               accept;
	logic [pmrt_pkg::KEY_W-1:0]         key_full;
	logic [KW-1:0]                      rd_key;
	logic signed [pmrt_pkg::RSSI_W-1:0] rd_best;
	logic                               slot_v;
	logic                               hit;
	logic                               at_end;
	logic                               consume;
	logic                               s1_open;
	logic                               issue;
	logic                               more;
	logic [SLOTS-1:0]                   above;

	assign sighting.ready = (state_q == ST_IDLE);
	assign accept         = sighting.valid && sighting.ready;
	assign key_full       = pmrt_pkg::name_key(sighting.peer_key, KEY_BYTES);

	assign rd_key  = ram_rdata[MW-1 -: KW];
	assign rd_best = $signed(ram_rdata[pmrt_pkg::RSSI_W-1:0]);
	assign slot_v  = valid_q[idx_s1];
	assign hit     = v_s1 && slot_v && (rd_key == key_q);
	assign at_end  = (idx_s1 == IW'(SLOTS - 1));
	assign more    = (iss_q < CW'(SLOTS));
	assign above   = (valid_q >> idx_s1) >> 1;

	// A flush slot leaves stage 1 when it is empty or the output register takes it.
	assign consume = v_s1 && (!slot_v || out_free);
	assign s1_open = !v_s1 || consume;

	always_comb begin
		issue = 1'b0;
		unique case (state_q)
			ST_NOTE:  issue = more;
			ST_FLUSH: issue = more && s1_open;
			ST_IDLE,
			ST_EMPTY: issue = 1'b0;
			default:  issue = 1'b0;
		endcase
	end

	assign ram_re    = issue;
	assign ram_raddr = iss_q[IW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = {key_q, rssi_q};
		if (state_q == ST_NOTE && v_s1) begin
			if (hit) begin
				ram_we = (rssi_q > rd_best);
			end else if (at_end) begin
				if (free_found_q) begin
					ram_we    = 1'b1;
					ram_waddr = free_idx_q;
				end else begin
					ram_we = !slot_v;
				end
			end
		end
	end

	always_comb begin
		push      = 1'b0;
		res.key   = pmrt_pkg::KEY_W'(rd_key);
		res.best  = rd_best;
		res.found = 1'b1;
		res.last  = (above == '0);
		if (state_q == ST_FLUSH) begin
			push = v_s1 && slot_v && out_free;
		end else if (state_q == ST_EMPTY) begin
			push      = out_free;
			res.key   = '0;
			res.best  = '0;
			res.found = 1'b0;
			res.last  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			iss_q        <= '0;
			v_s1         <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (issue) begin
				iss_q <= iss_q + CW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					v_s1 <= 1'b0;
					if (accept) begin
						iss_q        <= '0;
						free_found_q <= 1'b0;
						unique case (pmrt_pkg::func_t'(sighting.func))
							pmrt_pkg::FN_CLEAR: valid_q <= '0;
							pmrt_pkg::FN_NOTE:  state_q <= ST_NOTE;
							pmrt_pkg::FN_FLUSH: state_q <= (valid_q == '0) ? ST_EMPTY : ST_FLUSH;
							pmrt_pkg::FN_NONE:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_NOTE: begin
					v_s1 <= issue;
					if (v_s1) begin
						if (hit) begin
							state_q <= ST_IDLE;
						end else if (at_end) begin
							if (ram_we) begin
								valid_q[ram_waddr] <= 1'b1;
							end
							state_q <= ST_IDLE;
						end else if (!slot_v && !free_found_q) begin
							free_found_q <= 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (issue) begin
						v_s1 <= 1'b1;
					end else if (consume) begin
						v_s1 <= 1'b0;
					end
					if (push && res.last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMPTY: begin
					if (push) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= key_full[KW-1:0];
			rssi_q <= sighting.rssi;
		end
		if (issue) begin
			idx_s1 <= iss_q[IW-1:0];
		end
		if (state_q == ST_NOTE && v_s1 && !hit && !slot_v && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
	end

endmodule

// ===== tb/tb_peer_max_rssi_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_peer_max_rssi_table_unit
// Self-checking bench for the per-peer strongest RSSI table. A short table of
// directed sightings (empty flushes, name trimming, max keeping, full table)
// runs first, then about 450 random operations over a small name pool. Every
// report is compared with a scoreboard fed by a behavioural table model.
// Both channels idle at random, and the report sink holds off once for a long
// stretch so that the unit backs up into its sighting input.
// ----------------------------------------------------------------------------
module tb_peer_max_rssi_table_unit;
	import pmrt_pkg::*;

	localparam int TABLE_SLOTS  = SLOTS_DEF;
	localparam int NAME_BYTES   = KEY_BYTES_DEF;
	localparam int RANDOM_ITEMS = 450;
	localparam int POOL_SIZE    = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int TIMEOUT_NS   = 400_000;

	localparam res_t EMPTY_REPORT = '{key: '0, best: '0, found: 1'b0, last: 1'b1};

	typedef struct {
		func_t                    op;
		logic [KEY_W-1:0]         key;
		logic signed [RSSI_W-1:0] rssi;
		bit                       typed;
		res_t                     want;
	} stim_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	pmrt_in_if  sighting ();
	pmrt_out_if report ();

	peer_max_rssi_table_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.sighting (sighting),
		.report   (report)
	);

	// Shadow copy of the slot table
	logic                     mirror_valid [TABLE_SLOTS];
	logic [KEY_W-1:0]         mirror_key   [TABLE_SLOTS];
	logic signed [RSSI_W-1:0] mirror_best  [TABLE_SLOTS];

	res_t      expected_reports [$];
	stim_row_t directed_rows [$];
	int        mismatches = 0;
	bit        calm       = 1'b0;
	bit        hold_go    = 1'b0;

	always #1 clk = ~clk;

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

	// Name up to its first zero byte, at most NAME_BYTES long
	function automatic logic [KEY_W-1:0] trim_name(input logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] name;
		name = '0;
		for (int b = 0; b < NAME_BYTES; b++) begin
			if (raw[8*b +: 8] == 8'h00) break;
			name[8*b +: 8] = raw[8*b +: 8];
		end
		return name;
	endfunction

	function automatic void predict_reports(input func_t op, input logic [KEY_W-1:0] raw,
			input logic signed [RSSI_W-1:0] rssi, ref res_t outq[$]);
		logic [KEY_W-1:0] name;
		int               free_slot;
		int               last_used;
		bit               hit;
		name      = trim_name(raw);
		free_slot = -1;
		last_used = -1;
		hit       = 1'b0;
		case (op)
			FN_CLEAR: begin
				for (int s = 0; s < TABLE_SLOTS; s++) mirror_valid[s] = 1'b0;
			end
			FN_NOTE: begin
				for (int s = 0; s < TABLE_SLOTS; s++) begin
					if (!hit && mirror_valid[s] && mirror_key[s] == name) begin
						hit = 1'b1;
						if (rssi > mirror_best[s]) mirror_best[s] = rssi;
					end
					if (!mirror_valid[s] && free_slot < 0) free_slot = s;
				end
				// drop silently when the table is full
				if (!hit && free_slot >= 0) begin
					mirror_valid[free_slot] = 1'b1;
					mirror_key[free_slot]   = name;
					mirror_best[free_slot]  = rssi;
				end
			end
			FN_FLUSH: begin
				for (int s = 0; s < TABLE_SLOTS; s++) if (mirror_valid[s]) last_used = s;
				if (last_used < 0) begin
					outq.push_back(EMPTY_REPORT);
				end else begin
					for (int s = 0; s < TABLE_SLOTS; s++) begin
						if (mirror_valid[s]) begin
							outq.push_back('{key: mirror_key[s], best: mirror_best[s],
								found: 1'b1, last: (s == last_used)});
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void add_row(input func_t op, input logic [KEY_W-1:0] key,
			input logic signed [RSSI_W-1:0] rssi, input bit typed, input res_t want);
		directed_rows.push_back('{op: op, key: key, rssi: rssi, typed: typed, want: want});
	endfunction

	function automatic void check_field(input string field, input logic [KEY_W-1:0] want,
			input logic [KEY_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	task automatic offer_sighting(input func_t op, input logic [KEY_W-1:0] key,
			input logic signed [RSSI_W-1:0] rssi);
		while (!calm && $urandom_range(0, 99) < 33) begin
			sighting.valid <= 1'b0;
			@(posedge clk);
		end
		sighting.valid    <= 1'b1;
		sighting.func     <= op;
		sighting.peer_key <= key;
		sighting.rssi     <= rssi;
		do @(posedge clk); while (!sighting.ready);
	endtask

	// Report sink: random back-pressure plus one long hold-off
	initial begin : report_sink
		int   hold_left;
		bit   hold_done;
		res_t want;
		hold_left = 0;
		hold_done = 1'b0;
		report.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (report.valid && report.ready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected report: expected none, actual key %h rssi %0d found %b last %b",
						$time, report.out_key, report.peak_rssi, report.found, report.last);
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					check_field("out_key", want.key, report.out_key);
					check_field("peak_rssi", want.best, report.peak_rssi);
					check_field("found", want.found, report.found);
					check_field("last", want.last, report.last);
				end
			end
			if (hold_go && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				report.ready <= 1'b0;
			end else begin
				report.ready <= calm || ($urandom_range(0, 99) >= 33);
			end
		end
	end

	initial begin : stimulus
		res_t                     got [$];
		logic [KEY_W-1:0]         name_pool [POOL_SIZE];
		logic [KEY_W-1:0]         key;
		logic signed [RSSI_W-1:0] rssi;
		func_t                    op;
		int                       len;
		int                       pick;
		int                       counted;

		sighting.valid    <= 1'b0;
		sighting.func     <= FN_CLEAR;
		sighting.peer_key <= '0;
		sighting.rssi     <= '0;

		// empty table, unused selector, trimming, max keeping, full table
		add_row(FN_FLUSH, 64'h0, 8'sd0, 1'b1, EMPTY_REPORT);
		add_row(FN_NONE, 64'h1234_5678_9ABC_DEF0, -8'sd1, 1'b0, EMPTY_REPORT);
		add_row(FN_FLUSH, 64'h0, 8'sd0, 1'b1, EMPTY_REPORT);
		add_row(FN_NOTE, 64'h0, -8'sd128, 1'b0, EMPTY_REPORT);
		add_row(FN_NOTE, 64'hFFFF_FFFF_FFFF_FFFF, 8'sd127, 1'b0, EMPTY_REPORT);
		add_row(FN_NOTE, 64'h0000_0000_0000_4241, -8'sd50, 1'b0, EMPTY_REPORT);
		add_row(FN_NOTE, 64'hFFFF_0000_0000_4241, -8'sd60, 1'b0, EMPTY_REPORT);
		add_row(FN_NOTE, 64'h00A5_5A00_0000_4241, -8'sd20, 1'b0, EMPTY_REPORT);
		add_row(FN_NOTE, 64'h1122_3344_0055_6677, 8'sd5, 1'b0, EMPTY_REPORT);
		add_row(FN_NOTE, 64'hAABB_CCDD_EEFF_1100, 8'sd100, 1'b0, EMPTY_REPORT);
		add_row(FN_FLUSH, 64'h0, 8'sd0, 1'b0, EMPTY_REPORT);
		add_row(FN_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 8'sd127, 1'b0, EMPTY_REPORT);
		add_row(FN_FLUSH, 64'h0, 8'sd0, 1'b1, EMPTY_REPORT);
		for (int s = 0; s <= TABLE_SLOTS; s++) begin
			add_row(FN_NOTE, 64'h4E00 + 64'(s) + 1, 8'(-8'sd128 + 8'(s * 30)),
				1'b0, EMPTY_REPORT);
		end
		add_row(FN_NOTE, 64'h4E03, 8'sd127, 1'b0, EMPTY_REPORT);
		add_row(FN_FLUSH, 64'h0, 8'sd0, 1'b0, EMPTY_REPORT);

		for (int p = 0; p < POOL_SIZE; p++) begin
			len          = $urandom_range(1, NAME_BYTES);
			name_pool[p] = '0;
			for (int b = 0; b < len; b++) name_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
		end

		wait (arst_n);
		@(posedge clk);

		foreach (directed_rows[i]) begin
			offer_sighting(directed_rows[i].op, directed_rows[i].key, directed_rows[i].rssi);
			got.delete();
			predict_reports(directed_rows[i].op, directed_rows[i].key, directed_rows[i].rssi,
				got);
			if (directed_rows[i].typed) begin
				expected_reports.push_back(directed_rows[i].want);
			end else begin
				foreach (got[j]) expected_reports.push_back(got[j]);
			end
		end

		hold_go = 1'b1;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			calm = (counted >= 200 && counted < 280);
			pick = $urandom_range(0, 99);
			if (pick < 8) op = FN_CLEAR;
			else if (pick < 23) op = FN_FLUSH;
			else if (pick < 27) op = FN_NONE;
			else op = FN_NOTE;

			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				// known peer, at times with junk above the terminating zero byte
				key = name_pool[$urandom_range(0, POOL_SIZE - 1)];
				for (len = 0; len < NAME_BYTES && key[8*len +: 8] != 8'h00; len++);
				if (len < NAME_BYTES - 1 && $urandom_range(0, 1))
					key = key | ({$urandom, $urandom} << (8 * (len + 1)));
			end else if (pick < 60) begin
				key = {$urandom, $urandom} & ~64'hFF;
			end else begin
				key = {$urandom, $urandom};
			end
			rssi = 8'($urandom_range(0, 255));

			offer_sighting(op, key, rssi);
			got.delete();
			predict_reports(op, key, rssi, got);
			foreach (got[j]) expected_reports.push_back(got[j]);
			if (op != FN_NONE) counted++;
		end
		calm = 1'b0;
		sighting.valid <= 1'b0;

		while (expected_reports.size() != 0) @(posedge clk);
		repeat (4 * TABLE_SLOTS) @(posedge clk);

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
